>>> sv/sorted_tile_slot_table_macros.svh
// Assertion helpers for the sorted tile slot table.
// All of them sample on clk and are off while rst_n is low.
`ifndef SORTED_TILE_SLOT_TABLE_MACROS_SVH
`define SORTED_TILE_SLOT_TABLE_MACROS_SVH

// Check a condition at every edge.
`define STS_ASSERT_ALWAYS(label, cond, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// Check a consequence in the same cycle.
`define STS_ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Check a consequence in the next cycle.
`define STS_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> sv/sts_pkg.sv
`default_nettype none
package sts_pkg;

  localparam int MAX_SLOTS_DEF     = 256;
  localparam int POSITION_BITS_DEF = 16;
  localparam int KIND_W            = 16;
  localparam int IN_POS_W          = 16;
  localparam int OUT_IDX_W         = 8;
  localparam int STATUS_W          = 3;
  localparam int OUT_CNT_W         = 9;

  localparam logic [STATUS_W-1:0] ST_INSERTED  = 3'd0;
  localparam logic [STATUS_W-1:0] ST_UPDATED   = 3'd1;
  localparam logic [STATUS_W-1:0] ST_UNCHANGED = 3'd2;
  localparam logic [STATUS_W-1:0] ST_REMOVED   = 3'd3;
  localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 3'd4;
  localparam logic [STATUS_W-1:0] ST_FULL      = 3'd5;

  localparam logic MODE_SET    = 1'b0;
  localparam logic MODE_REMOVE = 1'b1;

  // Cell commands applied on commit
  localparam logic [1:0] CMD_NONE   = 2'd0;
  localparam logic [1:0] CMD_INSERT = 2'd1;
  localparam logic [1:0] CMD_UPDATE = 2'd2;
  localparam logic [1:0] CMD_REMOVE = 2'd3;

  typedef struct packed {
    logic                mode;
    logic [IN_POS_W-1:0] tile_position;
    logic [KIND_W-1:0]   tile_kind;
  } in_item_t;

  typedef struct packed {
    logic [OUT_IDX_W-1:0] slot_index;
    logic [STATUS_W-1:0]  status;
    logic [OUT_CNT_W-1:0] active_count;
  } out_item_t;

  typedef struct packed {
    logic       cmp_en;
    logic       commit;
    logic [1:0] cmd;
  } cell_ctl_t;

  typedef struct packed {
    logic hit;
    logic kind_diff;
  } chain_sts_t;

endpackage
`default_nettype wire

>>> sv/sts_cell.sv
`default_nettype none
module sts_cell #(
  parameter int POS_W = sts_pkg::POSITION_BITS_DEF
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  sts_pkg::cell_ctl_t        ctl,
  input  logic [POS_W-1:0]          req_pos,
  input  logic [sts_pkg::KIND_W-1:0] req_kind,
  input  logic                      active,
  input  logic                      left_ge,
  input  logic [POS_W-1:0]          left_pos,
  input  logic [sts_pkg::KIND_W-1:0] left_kind,
  input  logic [POS_W-1:0]          right_pos,
  input  logic [sts_pkg::KIND_W-1:0] right_kind,
  output logic [POS_W-1:0]          pos,
  output logic [sts_pkg::KIND_W-1:0] kind,
  output logic                      ge,
  output logic                      first,
  output logic                      hit,
  output logic                      kind_diff
);

  logic [POS_W-1:0]           pos_r, pos_nxt;
  logic [sts_pkg::KIND_W-1:0] kind_r, kind_nxt;
  logic                       ge_r, eq_r, kd_r;

  // ge_r marks slots at or past the lower bound (inactive slots count as past)
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ge_r <= 1'b1;
    end else if (ctl.cmp_en) begin
      ge_r <= !(active && (pos_r < req_pos));
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.cmp_en) begin
      eq_r <= active && (pos_r == req_pos);
      kd_r <= (kind_r != req_kind);
    end
  end

  assign first     = ge_r && !left_ge;
  assign hit       = first && eq_r;
  assign kind_diff = hit && kd_r;

  always_comb begin
    pos_nxt  = pos_r;
    kind_nxt = kind_r;
    if (ctl.commit) begin
      case (ctl.cmd)
        sts_pkg::CMD_INSERT: begin
          if (first) begin
            pos_nxt  = req_pos;
            kind_nxt = req_kind;
          end else if (left_ge) begin
            pos_nxt  = left_pos;
            kind_nxt = left_kind;
          end
        end
        sts_pkg::CMD_UPDATE: begin
          if (hit) begin
            kind_nxt = req_kind;
          end
        end
        sts_pkg::CMD_REMOVE: begin
          if (ge_r) begin
            pos_nxt  = right_pos;
            kind_nxt = right_kind;
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    pos_r  <= pos_nxt;
    kind_r <= kind_nxt;
  end

  assign pos  = pos_r;
  assign kind = kind_r;
  assign ge   = ge_r;

endmodule
`default_nettype wire

>>> sv/sts_chain.sv
`default_nettype none
module sts_chain #(
  parameter int MAX_SLOTS = sts_pkg::MAX_SLOTS_DEF,
  parameter int POS_W     = sts_pkg::POSITION_BITS_DEF,
  localparam int CNT_W    = $clog2(MAX_SLOTS + 1),
  localparam int IDX_W    = $clog2(MAX_SLOTS)
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  sts_pkg::cell_ctl_t         ctl,
  input  logic [POS_W-1:0]           req_pos,
  input  logic [sts_pkg::KIND_W-1:0] req_kind,
  input  logic [CNT_W-1:0]           cnt,
  output sts_pkg::chain_sts_t        sts,
  output logic [IDX_W-1:0]           idx
);

  logic [POS_W-1:0]           pos_a  [MAX_SLOTS];
  logic [sts_pkg::KIND_W-1:0] kind_a [MAX_SLOTS];
  logic [MAX_SLOTS-1:0]       ge_v, first_v, hit_v, kd_v, active_v;

  for (genvar j = 0; j < MAX_SLOTS; j++) begin : g_cell
    logic                       l_ge;
    logic [POS_W-1:0]           l_pos, r_pos;
    logic [sts_pkg::KIND_W-1:0] l_kind, r_kind;

    assign active_v[j] = (CNT_W'(j) < cnt);

    if (j == 0) begin : g_head
      assign l_ge   = 1'b0;
      assign l_pos  = pos_a[j];
      assign l_kind = kind_a[j];
    end else begin : g_body
      assign l_ge   = ge_v[j-1];
      assign l_pos  = pos_a[j-1];
      assign l_kind = kind_a[j-1];
    end

    if (j == MAX_SLOTS - 1) begin : g_tail
      assign r_pos  = pos_a[j];
      assign r_kind = kind_a[j];
    end else begin : g_mid
      assign r_pos  = pos_a[j+1];
      assign r_kind = kind_a[j+1];
    end

    sts_cell #(.POS_W(POS_W)) u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .ctl       (ctl),
      .req_pos   (req_pos),
      .req_kind  (req_kind),
      .active    (active_v[j]),
      .left_ge   (l_ge),
      .left_pos  (l_pos),
      .left_kind (l_kind),
      .right_pos (r_pos),
      .right_kind(r_kind),
      .pos       (pos_a[j]),
      .kind      (kind_a[j]),
      .ge        (ge_v[j]),
      .first     (first_v[j]),
      .hit       (hit_v[j]),
      .kind_diff (kd_v[j])
    );
  end

  assign sts.hit       = |hit_v;
  assign sts.kind_diff = |kd_v;

  // encode the one-hot lower-bound marker
  always_comb begin
    idx = '0;
    for (int j = 0; j < MAX_SLOTS; j++) begin
      if (first_v[j]) begin
        idx = idx | IDX_W'(j);
      end
    end
  end

endmodule
`default_nettype wire

>>> sv/sorted_tile_slot_table.sv
// Flow: an item is accepted, compared in all cells, then committed with the shift;
//   the result register is loaded on commit. No new item is accepted until then,
//   and the commit waits while the previous result is still held.
// Reset: synchronous active-low rst_n empties the table (count zero) and
//   drops any pending result; slot contents are not cleared.
`default_nettype none
`include "sorted_tile_slot_table_macros.svh"
module sorted_tile_slot_table #(
  parameter int MAX_SLOTS     = sts_pkg::MAX_SLOTS_DEF,
  parameter int POSITION_BITS = sts_pkg::POSITION_BITS_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  sts_pkg::in_item_t  in_item,
  output logic               out_valid,
  input  logic               out_stall,
  output sts_pkg::out_item_t out_item
);

  localparam int CNT_W = $clog2(MAX_SLOTS + 1);
  localparam int IDX_W = $clog2(MAX_SLOTS);

  // Sequencer: idle, compare, commit
  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_CMP  = 2'd1;
  localparam logic [1:0] S_UPD  = 2'd2;

  logic [1:0]                 state_r, state_nxt;
  logic [CNT_W-1:0]           cnt_r, cnt_nxt, res_cnt;
  logic                       mode_r;
  logic [POSITION_BITS-1:0]   pos_r, in_pos;
  logic [sts_pkg::KIND_W-1:0] kind_r;
  logic                       out_valid_r;
  sts_pkg::out_item_t         out_item_r;

  logic                       accept, commit, out_free, full;
  logic [1:0]                 cmd;
  logic [sts_pkg::STATUS_W-1:0] status;
  logic [IDX_W-1:0]           idx, res_idx;
  sts_pkg::cell_ctl_t         ctl;
  sts_pkg::chain_sts_t        sts;

  logic [POSITION_BITS+sts_pkg::IN_POS_W-1:0] pos_ext;
  logic [IDX_W+sts_pkg::OUT_IDX_W-1:0]        idx_ext;
  logic [CNT_W+sts_pkg::OUT_CNT_W-1:0]        cnt_ext;

  // Take one item at a time; hold the input off until the commit is done.
  assign in_stall = (state_r != S_IDLE);
  assign accept   = in_valid && !in_stall;

  // Drop position bits above POSITION_BITS, zero-extend when wider.
  assign pos_ext = {{POSITION_BITS{1'b0}}, in_item.tile_position};
  assign in_pos  = pos_ext[POSITION_BITS-1:0];

  always_ff @(posedge clk) begin
    if (accept) begin
      mode_r <= in_item.mode;
      pos_r  <= in_pos;
      kind_r <= in_item.tile_kind;
    end
  end

  // The output register parts both sides; commit only when it can take a result.
  assign out_free = !out_valid_r || !out_stall;
  assign commit   = (state_r == S_UPD) && out_free;
  assign full     = (cnt_r == CNT_W'(MAX_SLOTS));

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE:  if (accept) state_nxt = S_CMP;
      S_CMP:   state_nxt = S_UPD;
      S_UPD:   if (out_free) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  // Decide what the cells do and what the result says.
  always_comb begin
    cmd     = sts_pkg::CMD_NONE;
    status  = sts_pkg::ST_NOT_FOUND;
    res_idx = '0;
    res_cnt = cnt_r;
    if (mode_r == sts_pkg::MODE_SET) begin
      if (sts.hit) begin
        res_idx = idx;
        if (sts.kind_diff) begin
          cmd    = sts_pkg::CMD_UPDATE;
          status = sts_pkg::ST_UPDATED;
        end else begin
          status = sts_pkg::ST_UNCHANGED;
        end
      end else if (full) begin
        status = sts_pkg::ST_FULL;
      end else begin
        cmd     = sts_pkg::CMD_INSERT;
        status  = sts_pkg::ST_INSERTED;
        res_idx = idx;
        res_cnt = cnt_r + CNT_W'(1);
      end
    end else begin
      if (sts.hit) begin
        cmd     = sts_pkg::CMD_REMOVE;
        status  = sts_pkg::ST_REMOVED;
        res_idx = idx;
        res_cnt = cnt_r - CNT_W'(1);
      end
    end
  end

  assign cnt_nxt = commit ? res_cnt : cnt_r;

  assign ctl.cmp_en = (state_r == S_CMP);
  assign ctl.commit = commit;
  assign ctl.cmd    = cmd;

  sts_chain #(
    .MAX_SLOTS(MAX_SLOTS),
    .POS_W    (POSITION_BITS)
  ) u_chain (
    .clk     (clk),
    .rst_n   (rst_n),
    .ctl     (ctl),
    .req_pos (pos_r),
    .req_kind(kind_r),
    .cnt     (cnt_r),
    .sts     (sts),
    .idx     (idx)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      if (commit) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Truncate or widen index and count to the result field widths.
  assign idx_ext = {{sts_pkg::OUT_IDX_W{1'b0}}, res_idx};
  assign cnt_ext = {{sts_pkg::OUT_CNT_W{1'b0}}, res_cnt};

  always_ff @(posedge clk) begin
    if (commit) begin
      out_item_r.slot_index   <= idx_ext[sts_pkg::OUT_IDX_W-1:0];
      out_item_r.status       <= status;
      out_item_r.active_count <= cnt_ext[sts_pkg::OUT_CNT_W-1:0];
    end
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

  `STS_ASSERT_ALWAYS(a_cnt_bound, cnt_r <= CNT_W'(MAX_SLOTS), "slot count above capacity")
  `STS_ASSERT_IMPL(a_ins_room, commit && (cmd == sts_pkg::CMD_INSERT), !full, "insert into full table")
  `STS_ASSERT_IMPL(a_rem_nonempty, commit && (cmd == sts_pkg::CMD_REMOVE), cnt_r != '0, "remove from empty table")
  `STS_ASSERT_NEXT(a_cnt_hold, state_r != S_UPD, $stable(cnt_r), "count changed outside commit")
  `STS_ASSERT_NEXT(a_res_out, commit, out_valid_r, "commit without a result")

endmodule
`default_nettype wire
